// File: hdl/ssc_pkg.sv
// Servo sweep controller: shared types, constants and register map.
// No dependencies; every other file of the block imports this package.
package ssc_pkg;

  // Default width of the PWM duty word
  localparam int SSC_PWM_BITS = 16;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 10;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ANGLE    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PERIOD = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_SLOW    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_NORMAL  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_FAST    = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DWELL_SLOW   = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DWELL_NORMAL = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_DWELL_FAST   = 4'd7;

  // Register reset values
  localparam logic [7:0] RST_MAX_ANGLE    = 8'd125;
  localparam logic [7:0] RST_FRAME_PERIOD = 8'd20;
  localparam logic [6:0] RST_STEP_SLOW    = 7'd3;
  localparam logic [6:0] RST_STEP_NORMAL  = 7'd5;
  localparam logic [6:0] RST_STEP_FAST    = 7'd8;
  localparam logic [9:0] RST_DWELL_SLOW   = 10'd120;
  localparam logic [9:0] RST_DWELL_NORMAL = 10'd80;
  localparam logic [9:0] RST_DWELL_FAST   = 10'd40;

  // Speed codes after clamping
  localparam logic [1:0] SPEED_STOP   = 2'd0;
  localparam logic [1:0] SPEED_SLOW   = 2'd1;
  localparam logic [1:0] SPEED_NORMAL = 2'd2;
  localparam logic [1:0] SPEED_FAST   = 2'd3;

  // Servo geometry
  localparam logic [7:0]  FULL_DEG    = 8'd180;
  localparam logic [7:0]  RETURN_STEP = 8'd10;
  localparam int          MIN_US      = 500;
  localparam int          MAX_US      = 2500;
  localparam int          PERIOD_US   = 20000;

  // 2000/180 reduces to 100/9
  localparam int DEG_NUM = (MAX_US - MIN_US) / 20;
  localparam int DEG_DEN = 180 / 20;
  // ceil(2^17/9): exact floor for every numerator up to 100*180
  localparam int DIV9_SHIFT = 17;
  localparam int DIV9_RECIP = (1 << DIV9_SHIFT) / DEG_DEN + 1;

  // Command bundle from sequencer to datapath
  typedef struct packed {
    logic capture;  // latch the incoming tick
    logic step;     // update angle, direction and waits
    logic mul;      // scale the clamped angle
    logic pulse;    // pulse width and pulse*top
    logic recip;    // reciprocal estimate of the duty
    logic prod;     // back-multiply for the correction
    logic load;     // correct and fill the output register
  } ssc_cmd_t;

endpackage

// File: hdl/ssc_if.sv
// Servo sweep controller: valid/ready channel interfaces.
// Depends on ssc_pkg for the configuration port widths and the default PWM width.
interface ssc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] speed_cmd;
  modport source (output valid, output speed_cmd, input ready);
  modport sink   (input valid, input speed_cmd, output ready);
endinterface

interface ssc_out_if import ssc_pkg::*; #(parameter int PWM_BITS = SSC_PWM_BITS);
  logic                valid;
  logic                ready;
  logic [7:0]          angle_deg;
  logic [PWM_BITS-1:0] pwm_duty;
  logic                angle_written;
  logic                sweeping_up;
  modport source (output valid, output angle_deg, output pwm_duty,
                  output angle_written, output sweeping_up, input ready);
  modport sink   (input valid, input angle_deg, input pwm_duty,
                  input angle_written, input sweeping_up, output ready);
endinterface

interface ssc_cfg_if import ssc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: hdl/ssc_ctrl.sv
// Servo sweep controller: tick sequencer and output-beat valid flag.
// Depends on ssc_pkg for the command bundle.
module ssc_ctrl import ssc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ssc_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STEP  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_PULSE = 3'd3;
  localparam logic [2:0] ST_RECIP = 3'd4;
  localparam logic [2:0] ST_PROD  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.capture = accept;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_STEP;
      ST_STEP:  begin cmd_o.step  = 1'b1; state_d = ST_MUL;   end
      ST_MUL:   begin cmd_o.mul   = 1'b1; state_d = ST_PULSE; end
      ST_PULSE: begin cmd_o.pulse = 1'b1; state_d = ST_RECIP; end
      ST_RECIP: begin cmd_o.recip = 1'b1; state_d = ST_PROD;  end
      ST_PROD:  begin cmd_o.prod  = 1'b1; state_d = ST_DONE;  end
      ST_DONE: begin
        // hold the finished tick until the output register is free
        if (slot_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Output beat pending flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load)       out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hdl/ssc_datapath.sv
// Servo sweep controller: registers, sweep state update and duty arithmetic.
// Depends on ssc_pkg; driven by commands from ssc_ctrl.
module ssc_datapath import ssc_pkg::*; #(
  parameter int PWM_BITS = SSC_PWM_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ssc_cmd_t               cmd_i,
  input  logic [7:0]             speed_cmd_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic [7:0]             angle_deg_o,
  output logic [PWM_BITS-1:0]    pwm_duty_o,
  output logic                   angle_written_o,
  output logic                   sweeping_up_o
);

  // pulse*(2^PWM_BITS-1) stays below 2^YW
  localparam int YW       = 12 + PWM_BITS;
  localparam longint RCP  = (64'd1 << YW) / PERIOD_US;
  localparam int KW       = $clog2(RCP + 1);
  localparam int XW       = 15;  // 100*180
  localparam int QW       = 15;  // 20000

  // Configuration registers
  logic [7:0] max_angle_q, frame_period_q;
  logic [6:0] step_slow_q, step_normal_q, step_fast_q;
  logic [9:0] dwell_slow_q, dwell_normal_q, dwell_fast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_angle_q    <= RST_MAX_ANGLE;
      frame_period_q <= RST_FRAME_PERIOD;
      step_slow_q    <= RST_STEP_SLOW;
      step_normal_q  <= RST_STEP_NORMAL;
      step_fast_q    <= RST_STEP_FAST;
      dwell_slow_q   <= RST_DWELL_SLOW;
      dwell_normal_q <= RST_DWELL_NORMAL;
      dwell_fast_q   <= RST_DWELL_FAST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAX_ANGLE:    max_angle_q    <= cfg_data_i[7:0];
        REG_FRAME_PERIOD: frame_period_q <= cfg_data_i[7:0];
        REG_STEP_SLOW:    step_slow_q    <= cfg_data_i[6:0];
        REG_STEP_NORMAL:  step_normal_q  <= cfg_data_i[6:0];
        REG_STEP_FAST:    step_fast_q    <= cfg_data_i[6:0];
        REG_DWELL_SLOW:   dwell_slow_q   <= cfg_data_i;
        REG_DWELL_NORMAL: dwell_normal_q <= cfg_data_i;
        REG_DWELL_FAST:   dwell_fast_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Tick capture
  logic [7:0] speed_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) speed_q <= speed_cmd_i;
  end

  // Sweep state
  logic [7:0] angle_q, angle_n;
  logic       dir_q, dir_n;
  logic [7:0] frame_q, frame_n, frame_d;
  logic [9:0] dwell_q, dwell_n, dwell_d;
  logic       wr_q, wr_n;
  logic [1:0] spd;
  logic [6:0] step;
  logic [9:0] dwell_sel;
  logic [8:0] up_sum;

  assign spd = (speed_q > 8'd3) ? SPEED_FAST : speed_q[1:0];

  always_comb begin
    unique case (spd)
      SPEED_SLOW:   begin step = step_slow_q;   dwell_sel = dwell_slow_q;   end
      SPEED_NORMAL: begin step = step_normal_q; dwell_sel = dwell_normal_q; end
      SPEED_STOP,
      SPEED_FAST:   begin step = step_fast_q;   dwell_sel = dwell_fast_q;   end
      default:      begin step = step_fast_q;   dwell_sel = dwell_fast_q;   end
    endcase
  end

  // One frame step when both waits have run out, then count the waits down
  always_comb begin
    frame_n = frame_q;
    dwell_n = dwell_q;
    angle_n = angle_q;
    dir_n   = dir_q;
    wr_n    = 1'b0;
    up_sum  = {1'b0, angle_q} + {2'b00, step};
    if (frame_q == '0 && dwell_q == '0) begin
      frame_n = frame_period_q;
      if (spd == SPEED_STOP) begin
        // return to rest, nothing written once parked
        if (angle_q != '0) begin
          angle_n = (angle_q > RETURN_STEP) ? angle_q - RETURN_STEP : '0;
          wr_n    = 1'b1;
        end
      end else begin
        wr_n = 1'b1;
        if (dir_q) begin
          if (up_sum >= {1'b0, max_angle_q}) begin
            angle_n = max_angle_q;
            dir_n   = 1'b0;
            dwell_n = dwell_sel;
          end else begin
            angle_n = up_sum[7:0];
          end
        end else begin
          if (angle_q <= {1'b0, step}) begin
            angle_n = '0;
            dir_n   = 1'b1;
            dwell_n = dwell_sel;
          end else begin
            angle_n = angle_q - {1'b0, step};
          end
        end
      end
    end
    frame_d = (frame_n != '0) ? frame_n - 8'd1 : '0;
    dwell_d = (dwell_n != '0) ? dwell_n - 10'd1 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      dir_q   <= 1'b1;
      frame_q <= '0;
      dwell_q <= '0;
    end else if (cmd_i.step) begin
      angle_q <= angle_n;
      dir_q   <= dir_n;
      frame_q <= frame_d;
      dwell_q <= dwell_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) wr_q <= wr_n;
  end

  // Duty chain: 100*a, /9 and pulse*top, reciprocal of 20000, correction
  logic [7:0]         a_clamp;
  logic [XW-1:0]      x_q;
  logic [XW+13:0]     x_rcp;
  logic [11:0]        pulse;
  logic [YW-1:0]      y_q;
  logic [YW+KW-1:0]   y_rcp;
  logic [PWM_BITS-1:0] q0_q;
  logic [PWM_BITS+QW-1:0] p_q;
  logic [YW:0]        p_lim;
  logic [PWM_BITS-1:0] duty;

  assign a_clamp = (angle_q > FULL_DEG) ? FULL_DEG : angle_q;
  assign x_rcp   = {14'd0, x_q} * (XW+14)'(DIV9_RECIP);
  assign pulse   = 12'(MIN_US) + 12'(x_rcp >> DIV9_SHIFT);
  assign y_rcp   = {{KW{1'b0}}, y_q} * (YW+KW)'(RCP);
  // estimate is low by at most one
  assign p_lim   = (YW+1)'(p_q) + (YW+1)'(PERIOD_US);
  assign duty    = ({1'b0, y_q} >= p_lim) ? q0_q + 1'b1 : q0_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul)   x_q  <= XW'(a_clamp) * XW'(DEG_NUM);
    if (cmd_i.pulse) y_q  <= (YW'(pulse) << PWM_BITS) - YW'(pulse);
    if (cmd_i.recip) q0_q <= PWM_BITS'(y_rcp >> YW);
    if (cmd_i.prod)  p_q  <= (PWM_BITS+QW)'(q0_q) * (PWM_BITS+QW)'(PERIOD_US);
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      angle_deg_o     <= angle_q;
      pwm_duty_o      <= duty;
      angle_written_o <= wr_q;
      sweeping_up_o   <= dir_q;
    end
  end

endmodule

// File: hdl/servo_sweep_controller.sv
// Servo sweep controller: top level joining sequencer, datapath and channels.
// Depends on ssc_pkg, ssc_if, ssc_ctrl and ssc_datapath.
//
// Each beat on tick_i is one millisecond tick with a speed level (0 stop, 1 slow,
// 2 normal, 3 and above fast) and yields exactly one beat on result_o carrying
// the angle, the PWM duty for a 20 ms frame, a write strobe and the sweep
// direction. Once a tick is accepted, the sequencer runs the sweep step, then
// the registered duty chain (angle scale, pulse times full scale, reciprocal of
// the period, back-multiply for the correction), then the load into the output
// register. A new tick is taken no earlier than the cycle after that result is
// loaded, while the previous result may still wait on result_o; a result that
// cannot be loaded holds the input off. Configuration writes on cfg_i are always
// ready and must be issued only while no tick is in flight.
module servo_sweep_controller import ssc_pkg::*; #(
  parameter int PWM_BITS = SSC_PWM_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ssc_in_if.sink   tick_i,
  ssc_out_if.source result_o,
  ssc_cfg_if.sink  cfg_i
);

  ssc_cmd_t            cmd;
  logic [PWM_BITS-1:0] duty;

  assign cfg_i.ready = 1'b1;

  ssc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tick_i.valid),
    .in_ready_o  (tick_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  ssc_datapath #(.PWM_BITS(PWM_BITS)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .speed_cmd_i     (tick_i.speed_cmd),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.reg_index),
    .cfg_data_i      (cfg_i.wdata),
    .angle_deg_o     (result_o.angle_deg),
    .pwm_duty_o      (duty),
    .angle_written_o (result_o.angle_written),
    .sweeping_up_o   (result_o.sweeping_up)
  );

  assign result_o.pwm_duty = duty;

endmodule
